// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/utf8san_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8san_pkg
// Types, constants and byte tables shared by the utf-8 sanitiser modules.
// ----------------------------------------------------------------------------
package utf8san_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [1:0] CONT_TAG   = 2'b10;
  localparam logic [7:0] TWO_MASK   = 8'hE0;
  localparam logic [7:0] TWO_TAG    = 8'hC0;
  localparam logic [7:0] TWO_MIN    = 8'hC1;
  localparam logic [7:0] THREE_MASK = 8'hF0;
  localparam logic [7:0] THREE_TAG  = 8'hE0;
  localparam logic [7:0] FOUR_MASK  = 8'hF8;
  localparam logic [7:0] FOUR_TAG   = 8'hF0;
  localparam logic [7:0] FOUR_MAX   = 8'hF4;

  localparam logic [7:0] REPL_0 = 8'hEF;
  localparam logic [7:0] REPL_1 = 8'hBF;
  localparam logic [7:0] REPL_2 = 8'hBD;

  localparam logic [3:0] UNKNOWN_LEN = 4'd9;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } raw_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic       last_of_run;
  } clean_t;

  // work for one input byte: replacement triples first, then literal bytes
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      lit_cnt;
    logic [3:0][7:0] lits;
    logic            unknown;
    logic            marker;
    logic            last;
  } job_t;

  // sequence length opened by a lead byte, zero when it is no lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (((b & TWO_MASK) == TWO_TAG) && (b > TWO_MIN)) begin
      len = 3'd2;
    end else if ((b & THREE_MASK) == THREE_TAG) begin
      len = 3'd3;
    end else if (((b & FOUR_MASK) == FOUR_TAG) && (b <= FOUR_MAX)) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // byte of a run of replacement triples at a given position
  function automatic logic [7:0] repl_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0, 4'd3, 4'd6, 4'd9:  c = REPL_0;
      4'd1, 4'd4, 4'd7, 4'd10: c = REPL_1;
      default:                 c = REPL_2;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] unknown_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h3C; // <
      4'd1:    c = 8'h75; // u
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h6B; // k
      4'd4:    c = 8'h6E; // n
      4'd5:    c = 8'h6F; // o
      4'd6:    c = 8'h77; // w
      4'd7:    c = 8'h6E; // n
      4'd8:    c = 8'h3E; // >
      default: c = NUL_BYTE;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/utf8san_front.sv =====
// ----------------------------------------------------------------------------
// utf8san_front
// Takes raw bytes, tracks the open sequence and issues at most one job per byte.
// ----------------------------------------------------------------------------
module utf8san_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                raw_valid,
  output logic                raw_stall,
  input  utf8san_pkg::raw_t   raw,
  input  logic                full,
  output logic                push,
  output utf8san_pkg::job_t   job
);

  logic [7:0] held_bytes [3];
  logic [7:0] held_next  [3];
  logic [2:0] expected_length;
  logic [2:0] expected_length_next;
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic       emitted_any;
  logic       emitted_any_next;
  logic       accept;
  logic       fresh;
  logic       emitted;
  logic [2:0] lead_len;

  assign raw_stall = full;
  assign accept    = raw_valid && !full;

  always_comb begin
    job                  = '0;
    held_next            = held_bytes;
    expected_length_next = expected_length;
    held_count_next      = held_count;
    fresh                = 1'b1;
    lead_len             = utf8san_pkg::lead_length(raw.in_byte);

    if (expected_length != 3'd0) begin
      if (raw.in_byte[7:6] == utf8san_pkg::CONT_TAG) begin
        fresh = 1'b0;
        if (({1'b0, held_count} + 3'd1) >= expected_length) begin
          // sequence complete: held bytes then this one
          for (int k = 0; k < 3; k++) begin
            job.lits[k] = held_bytes[k];
          end
          job.lits[held_count] = raw.in_byte;
          job.lit_cnt          = {1'b0, held_count} + 3'd1;
          expected_length_next = 3'd0;
          held_count_next      = 2'd0;
        end else if (held_count != 2'd3) begin
          held_next[held_count] = raw.in_byte;
          held_count_next       = held_count + 2'd1;
        end
      end else begin
        // broken sequence
        job.rep_cnt          = {1'b0, held_count};
        expected_length_next = 3'd0;
        held_count_next      = 2'd0;
      end
    end

    if (fresh && (raw.in_byte != utf8san_pkg::NUL_BYTE)) begin
      if (!raw.in_byte[7]) begin
        job.lits[0] = raw.in_byte;
        job.lit_cnt = 3'd1;
      end else if (lead_len != 3'd0) begin
        held_next[0]         = raw.in_byte;
        held_count_next      = 2'd1;
        expected_length_next = lead_len;
      end else begin
        job.rep_cnt = job.rep_cnt + 3'd1;
      end
    end

    if (raw.end_of_input && (expected_length_next != 3'd0)) begin
      job.rep_cnt = job.rep_cnt + {1'b0, held_count_next};
    end

    emitted     = emitted_any || (job.rep_cnt != 3'd0) || (job.lit_cnt != 3'd0);
    job.last    = raw.end_of_input;
    job.unknown = raw.end_of_input && !emitted;
    job.marker  = raw.end_of_input && emitted_any &&
                  (job.rep_cnt == 3'd0) && (job.lit_cnt == 3'd0);

    emitted_any_next = emitted;
    if (raw.end_of_input) begin
      expected_length_next = 3'd0;
      held_count_next      = 2'd0;
      emitted_any_next     = 1'b0;
    end

    push = accept && ((job.rep_cnt != 3'd0) || (job.lit_cnt != 3'd0) || raw.end_of_input);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 3'd0;
      held_count      <= 2'd0;
      emitted_any     <= 1'b0;
    end else if (accept) begin
      expected_length <= expected_length_next;
      held_count      <= held_count_next;
      emitted_any     <= emitted_any_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_next;
    end
  end

endmodule

// ===== hw/rtl/utf8san_queue.sv =====
// ----------------------------------------------------------------------------
// utf8san_queue
// Small job fifo between the front and the back.
// ----------------------------------------------------------------------------
module utf8san_queue #(
  parameter int DEPTH = utf8san_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8san_pkg::job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output utf8san_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8san_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/utf8san_back.sv =====
// ----------------------------------------------------------------------------
// utf8san_back
// Expands the head job into output beats, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module utf8san_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  utf8san_pkg::job_t    head,
  output logic                 pop,
  output logic                 clean_valid,
  input  logic                 clean_stall,
  output utf8san_pkg::clean_t  clean
);

  logic [3:0]          pos;
  logic [3:0]          pos_inc;
  logic [4:0]          rep3;
  logic [4:0]          run_len_wide;
  logic [3:0]          run_len;
  logic [1:0]          lit_idx;
  logic                final_beat;
  logic                load;
  utf8san_pkg::clean_t beat;

  assign load         = head_valid && (!clean_valid || !clean_stall);
  assign rep3         = {head.rep_cnt, 1'b0} + {2'b00, head.rep_cnt};
  assign run_len_wide = rep3 + {2'b00, head.lit_cnt};
  assign pos_inc      = pos + 4'd1;
  assign lit_idx      = 2'(pos - rep3[3:0]);

  always_comb begin
    if (head.unknown) begin
      run_len = utf8san_pkg::UNKNOWN_LEN;
    end else if (head.marker) begin
      run_len = 4'd1;
    end else begin
      run_len = run_len_wide[3:0];
    end
    final_beat = (pos_inc == run_len);

    if (head.unknown) begin
      beat.out_byte = utf8san_pkg::unknown_char(pos);
    end else if (head.marker) begin
      beat.out_byte = utf8san_pkg::NUL_BYTE;
    end else if ({1'b0, pos} < rep3) begin
      beat.out_byte = utf8san_pkg::repl_char(pos);
    end else begin
      beat.out_byte = head.lits[lit_idx];
    end
    beat.has_byte      = !head.marker;
    beat.end_of_string = head.last && final_beat;
    beat.last_of_run   = final_beat;

    pop = load && final_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= 4'd0;
      clean_valid <= 1'b0;
    end else begin
      if (load) begin
        pos         <= final_beat ? 4'd0 : pos_inc;
        clean_valid <= 1'b1;
      end else if (!clean_stall) begin
        clean_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      clean <= beat;
    end
  end

endmodule

// ===== hw/rtl/utf8_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Byte-serial utf-8 cleaner with a decoupled classifier and byte expander.
// ----------------------------------------------------------------------------
// Takes one raw byte per beat on the raw channel and gives sanitised bytes on
// the clean channel. NUL bytes are dropped, ascii passes through, well-formed
// two, three and four byte sequences leave whole once complete, and anything
// else (stray bytes, broken sequences, a sequence cut off by the end of the
// string) turns into EF BF BD per offending byte. A string with no output at
// all becomes "<unknown>"; a final byte that would give nothing yields a
// marker beat with has_byte low. An input byte is taken whenever the job
// queue has room, and it causes between 0 and 12 output beats; the output
// register delivers one beat per cycle while clean_stall is low and a job is
// waiting, so sustained throughput is one output byte per clock, set by that
// single output byte lane. The first output beat of a byte passes through the
// job queue and then the output register before it is offered.
// ----------------------------------------------------------------------------
module utf8_sanitizer #(
  parameter int QUEUE_DEPTH = utf8san_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                raw_valid,
  output logic                raw_stall,
  input  utf8san_pkg::raw_t   raw,
  output logic                clean_valid,
  input  logic                clean_stall,
  output utf8san_pkg::clean_t clean
);

  // front to queue
  logic              push;
  utf8san_pkg::job_t push_job;
  logic              full;

  // queue to back
  logic              head_valid;
  utf8san_pkg::job_t head;
  logic              pop;

  // front: holds the open sequence and turns each byte into at most one job
  utf8san_front u_front (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw       (raw),
    .full      (full),
    .push      (push),
    .job       (push_job)
  );

  // queue: absorbs replacement bursts so the front keeps taking bytes
  utf8san_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: walks each job byte by byte into the output register
  utf8san_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .clean_valid (clean_valid),
    .clean_stall (clean_stall),
    .clean       (clean)
  );

endmodule

// ===== hw/rtl/utf8san_checker.sv =====
// ----------------------------------------------------------------------------
// utf8san_checker
// Port-level checks on the clean channel of the sanitiser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8san_checker (
  input logic                clk,
  input logic                rst,
  input logic                clean_valid,
  input logic                clean_stall,
  input utf8san_pkg::clean_t clean
);

  logic marker_ok;

  assign marker_ok = (clean.out_byte == utf8san_pkg::NUL_BYTE) &&
                     clean.end_of_string && clean.last_of_run;

  // a stalled beat stays offered
  `ASSERT_NEXT(a_valid_held, clean_valid && clean_stall, clean_valid)

  // a marker beat carries no byte and closes the string
  `ASSERT_IMP(a_marker_shape, clean_valid && !clean.has_byte, marker_ok)

  // end of string is always the end of a run
  `ASSERT_IMP(a_eos_ends_run, clean_valid && clean.end_of_string, clean.last_of_run)

  // NUL never reaches the output on a beat that carries a byte
  `ASSERT_IMP(a_no_nul, clean_valid && clean.has_byte, clean.out_byte != utf8san_pkg::NUL_BYTE)

endmodule

bind utf8_sanitizer utf8san_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .clean_valid (clean_valid),
  .clean_stall (clean_stall),
  .clean       (clean)
);
